// ===== rtl/fct_pkg.sv =====
// Shared types and constants for the chain file table.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;
  localparam logic [7:0] NO_SECTOR = 8'hFF;

  typedef enum logic [2:0] {
    MODE_FORMAT = 3'd0,
    MODE_NEW    = 3'd1,
    MODE_SIZE   = 3'd2,
    MODE_APPEND = 3'd3,
    MODE_LOCATE = 3'd4,
    MODE_LOAD   = 3'd5,
    MODE_READ   = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  // Memory access request from the sequencer to the table store.
  typedef struct packed {
    logic       we;
    logic       sel;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/fct_store.sv =====
// Directory and link tables: two memories that share one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fct_store (
  input  wire logic              clk,
  input  wire fct_pkg::mem_req_t req,
  output logic [7:0]             rdata
);
  import fct_pkg::*;

  logic [7:0] dir_mem [256];
  logic [7:0] link_mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      if (req.sel) link_mem[req.addr] <= req.wdata;
      else dir_mem[req.addr] <= req.wdata;
    end
    rdata <= req.sel ? link_mem[req.addr] : dir_mem[req.addr];
  end
endmodule
`default_nettype wire

// ===== rtl/fat_chain_file_table.sv =====
// Top level of the chain file table: request sequencer and table store.
`timescale 1ns / 1ps
`default_nettype none
// Each item runs on a small sequencer that shares one table read port; every
// table read is an address state followed by a check of the registered data.
// Format and the clearing pass after reset sweep both tables one entry a
// cycle and accept no item meanwhile. New file reads up to 255 directory
// slots. Size and locate read one link per step of the chain. Append walks
// every file chain from slot 0 up, then the chain of the target file. With
// disjoint chains that is at most about 770 reads, but files whose chains
// share sectors are walked again from every slot, so the worst case is about
// 66,000 reads. Load and read entry go from the directory read state through
// the check state to the done state. A result waits in an output register
// until taken.
module fat_chain_file_table #(
  parameter int NUM_SECTORS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            ready,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] file_num,
  input  wire logic [7:0] location,
  input  wire logic       table_select,
  input  wire logic [7:0] entry_index,
  input  wire logic [7:0] entry_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      value
);
  import fct_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIR_RD, S_DIR_CHK, S_LINK_RD, S_LINK_CHK,
    S_TGT_RD, S_TGT_CHK, S_WRITE, S_DONE
  } state_t;

  // Phases of append: scanning all files, then the target file.
  localparam logic PH_SCAN = 1'b0;
  localparam logic PH_TGT  = 1'b1;

  state_t     state;
  mode_t      op;
  logic [7:0] fnum, loc, eidx, eval;
  logic       tsel;
  logic [8:0] idx;     // directory slot or sweep index
  logic [8:0] steps;   // link reads in the current walk
  logic [7:0] cur;
  logic [8:0] next_sec;
  logic       phase;
  logic [7:0] first;
  mem_req_t   req;
  logic [7:0] rdata;

  fct_store u_store (.clk(clk), .req(req), .rdata(rdata));

  assign ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    req = '0;
    case (state)
      S_CLEAR: begin
        req.we = 1'b1; req.sel = idx[8]; req.addr = idx[7:0]; req.wdata = NO_SECTOR;
      end
      S_DIR_RD: begin
        req.addr = (op == MODE_NEW || op == MODE_APPEND) ? idx[7:0] : fnum;
        if (op == MODE_READ || op == MODE_LOAD) begin
          req.sel = tsel; req.addr = eidx;
          req.we = (op == MODE_LOAD); req.wdata = eval;
        end
      end
      S_TGT_RD: req.addr = fnum;
      S_LINK_RD: begin
        req.sel = 1'b1; req.addr = cur;
      end
      S_WRITE: begin
        req.we = 1'b1; req.wdata = next_sec[7:0];
        req.sel = (first != NO_SECTOR); req.addr = (first == NO_SECTOR) ? fnum : cur;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      op <= MODE_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          idx <= idx + 9'd1;
          if (idx == 9'd511) begin
            state <= (op == MODE_FORMAT) ? S_DONE : S_IDLE;
            status <= ST_OK; value <= '0;
          end
        end
        S_IDLE: begin
          if (valid && ready) begin
            op <= mode_t'(mode);
            fnum <= file_num; loc <= location; tsel <= table_select;
            eidx <= entry_index; eval <= entry_value;
            idx <= '0; next_sec <= '0; phase <= PH_SCAN;
            status <= ST_OK; value <= '0;
            case (mode_t'(mode))
              MODE_FORMAT: state <= S_CLEAR;
              MODE_NONE:   state <= S_DONE;
              default:     state <= S_DIR_RD;
            endcase
          end
        end
        S_DIR_RD: state <= S_DIR_CHK;
        S_DIR_CHK: begin
          steps <= 9'd1; cur <= rdata;
          case (op)
            MODE_NEW: begin
              if (rdata == NO_SECTOR) begin
                value <= idx[7:0]; state <= S_DONE;
              end else if (idx == 9'd254) begin
                status <= ST_EMPTY; state <= S_DONE;
              end else begin
                idx <= idx + 9'd1; state <= S_DIR_RD;
              end
            end
            MODE_SIZE: begin
              if (rdata == NO_SECTOR) state <= S_DONE;
              else state <= S_LINK_RD;
            end
            MODE_LOCATE: begin
              if (rdata == NO_SECTOR) begin
                status <= ST_EMPTY; state <= S_DONE;
              end else if (loc == 8'd0) begin
                value <= rdata; state <= S_DONE;
              end else state <= S_LINK_RD;
            end
            MODE_APPEND: begin
              if (rdata == NO_SECTOR) begin
                phase <= PH_TGT; state <= S_TGT_RD;
              end else state <= S_LINK_RD;
            end
            default: begin
              value <= (op == MODE_LOAD) ? eval : rdata;
              state <= S_DONE;
            end
          endcase
        end
        S_LINK_RD: state <= S_LINK_CHK;
        S_LINK_CHK: begin
          if (op == MODE_LOCATE) begin
            if (rdata == NO_SECTOR) begin
              status <= ST_EMPTY; state <= S_DONE;
            end else if (steps[7:0] == loc) begin
              value <= rdata; state <= S_DONE;
            end else begin
              cur <= rdata; steps <= steps + 9'd1; state <= S_LINK_RD;
            end
          end else if (rdata == NO_SECTOR) begin
            if (op == MODE_SIZE) begin
              value <= steps[7:0]; state <= S_DONE;
            end else if (phase == PH_SCAN) begin
              if ({1'b0, cur} + 9'd1 > next_sec) next_sec <= {1'b0, cur} + 9'd1;
              if (idx == 9'd255) begin
                phase <= PH_TGT; state <= S_TGT_RD;
              end else begin
                idx <= idx + 9'd1; state <= S_DIR_RD;
              end
            end else begin
              if (next_sec >= {1'b0, NO_SECTOR} || next_sec >= 9'(NUM_SECTORS)) begin
                status <= ST_EMPTY; state <= S_DONE;
              end else state <= S_WRITE;
            end
          end else if (steps == 9'd256) begin
            status <= ST_CORRUPT; state <= S_DONE;
          end else begin
            cur <= rdata; steps <= steps + 9'd1; state <= S_LINK_RD;
          end
        end
        S_TGT_RD: state <= S_TGT_CHK;
        S_TGT_CHK: begin
          first <= rdata; cur <= rdata; steps <= 9'd1;
          if (rdata != NO_SECTOR) state <= S_LINK_RD;
          else if (next_sec >= {1'b0, NO_SECTOR} || next_sec >= 9'(NUM_SECTORS)) begin
            status <= ST_EMPTY; state <= S_DONE;
          end else state <= S_WRITE;
        end
        S_WRITE: begin
          value <= next_sec[7:0]; state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
